// ----- hw/rtl/morse_text_codec_macros.svh -----
// Assertion helpers used by the checker file.
`ifndef MORSE_TEXT_CODEC_MACROS_SVH
`define MORSE_TEXT_CODEC_MACROS_SVH

// Clocked check, off while reset is asserted.
`define MTC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("morse_text_codec check failed");

// Clocked check that also runs through reset.
`define MTC_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("morse_text_codec check failed");

`endif

// ----- hw/rtl/mtc_pkg.sv -----
// ----------------------------------------------------------------------------
// mtc_pkg
// Shared constants, symbol table, job descriptor and lookup helpers for the
// Morse text codec.
// ----------------------------------------------------------------------------
`default_nettype none

package mtc_pkg;

    localparam int MAX_CODE_LEN_DEFAULT = 5;
    localparam int QUEUE_DEPTH_DEFAULT  = 2;

    // longest code in the symbol table
    localparam int TAB_MAX_LEN = 5;
    localparam int SYM_LEN_W   = 3;
    localparam int TAB_SIZE    = 36;

    // configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_DIRECTION = 1'b0;

    localparam logic DIR_ENCODE = 1'b0;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_QMARK = 8'h3F;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_LOW_A = 8'h61;
    localparam logic [7:0] CH_LOW_Z = 8'h7A;
    localparam logic [7:0] CASE_OFS = 8'h20;

    // {char, length, symbols}; symbol bit i set for a dash at position i
    localparam logic [15:0] MORSE_TAB [TAB_SIZE] = '{
        {"A", 3'd2, 5'b00010}, {"B", 3'd4, 5'b00001}, {"C", 3'd4, 5'b00101},
        {"D", 3'd3, 5'b00001}, {"E", 3'd1, 5'b00000}, {"F", 3'd4, 5'b00100},
        {"G", 3'd3, 5'b00011}, {"H", 3'd4, 5'b00000}, {"I", 3'd2, 5'b00000},
        {"J", 3'd4, 5'b01110}, {"K", 3'd3, 5'b00101}, {"L", 3'd4, 5'b00010},
        {"M", 3'd2, 5'b00011}, {"N", 3'd2, 5'b00001}, {"O", 3'd3, 5'b00111},
        {"P", 3'd4, 5'b00110}, {"Q", 3'd4, 5'b01011}, {"R", 3'd3, 5'b00010},
        {"S", 3'd3, 5'b00000}, {"T", 3'd1, 5'b00001}, {"U", 3'd3, 5'b00100},
        {"V", 3'd4, 5'b01000}, {"W", 3'd3, 5'b00110}, {"X", 3'd4, 5'b01001},
        {"Y", 3'd4, 5'b01101}, {"Z", 3'd4, 5'b00011}, {"1", 3'd5, 5'b11110},
        {"2", 3'd5, 5'b11100}, {"3", 3'd5, 5'b11000}, {"4", 3'd5, 5'b10000},
        {"5", 3'd5, 5'b00000}, {"6", 3'd5, 5'b00001}, {"7", 3'd5, 5'b00011},
        {"8", 3'd5, 5'b00111}, {"9", 3'd5, 5'b01111}, {"0", 3'd5, 5'b11111}
    };

    // One queued job: symbols first, then literal char, space, newline.
    typedef struct packed {
        logic [SYM_LEN_W-1:0]   sym_len;
        logic [TAB_MAX_LEN-1:0] sym_bits;
        logic                   ch_vld;
        logic [7:0]             ch;
        logic                   sp_vld;
        logic                   nl_vld;
    } job_t;

    typedef struct packed {
        logic                   found;
        logic [SYM_LEN_W-1:0]   len;
        logic [TAB_MAX_LEN-1:0] sym;
    } enc_t;

    // Character to code; entries are unique so matches are OR-merged.
    function automatic enc_t morse_encode(input logic [7:0] ch);
        enc_t r;
        r = '0;
        for (int i = 0; i < TAB_SIZE; i++) begin
            if (MORSE_TAB[i][15:8] == ch) begin
                r.found = 1'b1;
                r.len   = r.len | MORSE_TAB[i][7:5];
                r.sym   = r.sym | MORSE_TAB[i][4:0];
            end
        end
        return r;
    endfunction

    // Code to character, zero when nothing matches.
    function automatic logic [7:0] morse_decode(input logic [SYM_LEN_W-1:0] len,
                                                input logic [TAB_MAX_LEN-1:0] sym);
        logic [7:0] r;
        r = '0;
        for (int i = 0; i < TAB_SIZE; i++) begin
            if (MORSE_TAB[i][7:5] == len && MORSE_TAB[i][4:0] == sym) begin
                r = r | MORSE_TAB[i][15:8];
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/mtc_front.sv -----
// ----------------------------------------------------------------------------
// mtc_front
// Accepts input characters, tracks the pending decode code and turns each
// character that yields output into a job descriptor for the output sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module mtc_front #(
    parameter int MAX_CODE_LEN = 5
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          direction,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire logic [7:0]    s_in_char,
    input  wire logic          s_end_of_text,
    input  wire logic          q_full,
    output logic               q_push,
    output mtc_pkg::job_t      q_data
);
    import mtc_pkg::*;

    localparam int LEN_W = $clog2(MAX_CODE_LEN + 1);

    logic [MAX_CODE_LEN-1:0] code_sym_reg, code_sym_next;
    logic [LEN_W-1:0]        code_len_reg, code_len_next;
    logic                    code_bad_reg, code_bad_next;
    logic                    code_slash_reg, code_slash_next;

    logic [MAX_CODE_LEN-1:0] add_sym;
    logic [LEN_W-1:0]        add_len;
    logic                    add_bad, add_slash;
    logic [7:0]              upper, r_now, r_add;
    logic                    accept;
    enc_t                    enc;
    job_t                    job;

    function automatic logic [7:0] lookup(input logic [MAX_CODE_LEN-1:0] sym,
                                          input logic [LEN_W-1:0] len,
                                          input logic bad,
                                          input logic slash);
        logic [7:0] r;
        r = '0;
        if (bad) begin
            r = '0;
        end else if (slash) begin
            r = CH_SPACE;
        end else if (len != '0 && len <= LEN_W'(TAB_MAX_LEN)) begin
            r = morse_decode(len[SYM_LEN_W-1:0], sym[TAB_MAX_LEN-1:0]);
        end
        return r;
    endfunction

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    always_comb begin
        // collect one symbol into the pending code
        add_sym   = code_sym_reg;
        add_len   = code_len_reg;
        add_bad   = code_bad_reg;
        add_slash = code_slash_reg;
        if (s_in_char == CH_DOT || s_in_char == CH_DASH) begin
            if (code_slash_reg || code_len_reg >= LEN_W'(MAX_CODE_LEN)) begin
                add_bad = 1'b1;
            end else begin
                if (s_in_char == CH_DASH) begin
                    add_sym = code_sym_reg | (MAX_CODE_LEN'(1) << code_len_reg);
                end
                add_len = code_len_reg + LEN_W'(1);
            end
        end else if (s_in_char == CH_SLASH) begin
            if (code_len_reg != '0 || code_bad_reg || code_slash_reg) begin
                add_bad = 1'b1;
            end else begin
                add_slash = 1'b1;
            end
        end else begin
            add_bad = 1'b1;
        end

        r_now = lookup(code_sym_reg, code_len_reg, code_bad_reg, code_slash_reg);
        r_add = lookup(add_sym, add_len, add_bad, add_slash);

        upper = (s_in_char >= CH_LOW_A && s_in_char <= CH_LOW_Z) ?
                s_in_char - CASE_OFS : s_in_char;
        enc   = morse_encode(upper);

        job             = '0;
        job.nl_vld      = s_end_of_text;
        code_sym_next   = code_sym_reg;
        code_len_next   = code_len_reg;
        code_bad_next   = code_bad_reg;
        code_slash_next = code_slash_reg;

        if (direction == DIR_ENCODE) begin
            job.sp_vld = 1'b1;
            if (upper == CH_SPACE) begin
                job.ch_vld = 1'b1;
                job.ch     = CH_SLASH;
            end else if (enc.found) begin
                job.sym_len  = enc.len;
                job.sym_bits = enc.sym;
            end else begin
                job.ch_vld = 1'b1;
                job.ch     = CH_QMARK;
            end
        end else if (s_in_char == CH_SPACE) begin
            job.ch_vld      = 1'b1;
            job.ch          = (r_now != '0) ? r_now : CH_QMARK;
            code_sym_next   = '0;
            code_len_next   = '0;
            code_bad_next   = 1'b0;
            code_slash_next = 1'b0;
        end else if (s_end_of_text) begin
            // end of text flushes a valid pending code
            job.ch_vld      = (r_add != '0);
            job.ch          = r_add;
            code_sym_next   = '0;
            code_len_next   = '0;
            code_bad_next   = 1'b0;
            code_slash_next = 1'b0;
        end else begin
            code_sym_next   = add_sym;
            code_len_next   = add_len;
            code_bad_next   = add_bad;
            code_slash_next = add_slash;
        end
    end

    // characters that produce no output never enter the queue
    assign q_push = accept && (job.sym_len != '0 || job.ch_vld || job.sp_vld || job.nl_vld);
    assign q_data = job;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            code_sym_reg   <= '0;
            code_len_reg   <= '0;
            code_bad_reg   <= 1'b0;
            code_slash_reg <= 1'b0;
        end else if (accept) begin
            code_sym_reg   <= code_sym_next;
            code_len_reg   <= code_len_next;
            code_bad_reg   <= code_bad_next;
            code_slash_reg <= code_slash_next;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/mtc_queue.sv -----
// ----------------------------------------------------------------------------
// mtc_queue
// Small register FIFO of job descriptors between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module mtc_queue #(
    parameter int DEPTH = 2
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           push,
    input  wire mtc_pkg::job_t  push_data,
    output logic                full,
    input  wire logic           pop,
    output logic                vld,
    output mtc_pkg::job_t       pop_data
);
    import mtc_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign full     = (cnt_reg == CNT_W'(DEPTH));
    assign vld      = (cnt_reg != '0);
    assign pop_data = mem_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && vld;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/mtc_back.sv -----
// ----------------------------------------------------------------------------
// mtc_back
// Output sequencer: walks the current job one character per cycle into a
// registered result stage, holding while a result waits on m_ready.
// ----------------------------------------------------------------------------
`default_nettype none

module mtc_back (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           q_vld,
    input  wire mtc_pkg::job_t  q_data,
    output logic                q_pop,
    output logic                m_valid,
    input  wire logic           m_ready,
    output logic [7:0]          m_out_char,
    output logic                m_last
);
    import mtc_pkg::*;

    job_t       cur_reg, cur_next;
    logic       cur_vld_reg, cur_vld_next;
    logic       out_vld_reg, out_vld_next;
    logic [7:0] out_char_reg, out_char_next;
    logic       out_last_reg, out_last_next;

    job_t       after;
    logic [7:0] ch_o;
    logic       is_last, emit;

    always_comb begin
        after = cur_reg;
        ch_o  = CH_NL;
        if (cur_reg.sym_len != '0) begin
            ch_o           = cur_reg.sym_bits[0] ? CH_DASH : CH_DOT;
            after.sym_bits = cur_reg.sym_bits >> 1;
            after.sym_len  = cur_reg.sym_len - SYM_LEN_W'(1);
        end else if (cur_reg.ch_vld) begin
            ch_o         = cur_reg.ch;
            after.ch_vld = 1'b0;
        end else if (cur_reg.sp_vld) begin
            ch_o         = CH_SPACE;
            after.sp_vld = 1'b0;
        end else begin
            ch_o         = CH_NL;
            after.nl_vld = 1'b0;
        end
        is_last = (after.sym_len == '0) && !after.ch_vld && !after.sp_vld && !after.nl_vld;

        emit  = cur_vld_reg && (!out_vld_reg || m_ready);
        // next job loads in the cycle the current one emits its last char
        q_pop = q_vld && (!cur_vld_reg || (emit && is_last));

        cur_next      = cur_reg;
        cur_vld_next  = cur_vld_reg;
        out_vld_next  = out_vld_reg;
        out_char_next = out_char_reg;
        out_last_next = out_last_reg;

        if (emit) begin
            out_vld_next  = 1'b1;
            out_char_next = ch_o;
            out_last_next = is_last;
            cur_next      = after;
            if (is_last) begin
                cur_vld_next = 1'b0;
            end
        end else if (m_ready) begin
            out_vld_next = 1'b0;
        end
        if (q_pop) begin
            cur_next     = q_data;
            cur_vld_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            cur_vld_reg <= cur_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg      <= cur_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
    end

    assign m_valid    = out_vld_reg;
    assign m_out_char = out_char_reg;
    assign m_last     = out_last_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/morse_text_codec.sv -----
// A first result passes the job queue, the current-job register and the result register.
// Throughput: one result per cycle from the output sequencer while results are taken;
// a character has 1 to 7 results, and one that yields none never enters the queue.
// Input stalls only when the job queue between front and sequencer is full.
// Reset (aresetn low, synchronous) clears direction to encode, the pending code and queue.
// ----------------------------------------------------------------------------
// morse_text_codec
// ASCII text to Morse text converter and back, selected by the direction
// register; front classifier, job queue and output sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module morse_text_codec #(
    parameter int MAX_CODE_LEN = mtc_pkg::MAX_CODE_LEN_DEFAULT,
    parameter int QUEUE_DEPTH  = mtc_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic [7:0]                     s_in_char,
    input  wire logic                           s_end_of_text,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic [7:0]                          m_out_char,
    output logic                                m_last,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [mtc_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [mtc_pkg::APB_DATA_W-1:0] pwdata,
    output logic [mtc_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready
);
    import mtc_pkg::*;

    logic direction_reg, direction_next;
    logic reg_idx;
    logic q_push, q_full, q_pop, q_vld;
    job_t push_job, pop_job;

    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_ADDR_W-1];

    always_comb begin
        direction_next = direction_reg;
        if (psel && penable && pwrite && pready && reg_idx == REG_DIRECTION) begin
            direction_next = pwdata[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            direction_reg <= DIR_ENCODE;
        end else begin
            direction_reg <= direction_next;
        end
    end

    assign prdata = (reg_idx == REG_DIRECTION) ?
                    {{(APB_DATA_W - 1){1'b0}}, direction_reg} : '0;

    mtc_front #(
        .MAX_CODE_LEN (MAX_CODE_LEN)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .direction     (direction_reg),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_in_char     (s_in_char),
        .s_end_of_text (s_end_of_text),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_data        (push_job)
    );

    mtc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (push_job),
        .full      (q_full),
        .pop       (q_pop),
        .vld       (q_vld),
        .pop_data  (pop_job)
    );

    mtc_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_vld      (q_vld),
        .q_data     (pop_job),
        .q_pop      (q_pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_char (m_out_char),
        .m_last     (m_last)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/mtc_checker.sv -----
// ----------------------------------------------------------------------------
// mtc_checker
// Port-level checks for the Morse text codec, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "morse_text_codec_macros.svh"

module mtc_checker (
    input wire logic                           aclk,
    input wire logic                           aresetn,
    input wire logic                           m_valid,
    input wire logic                           m_ready,
    input wire logic [7:0]                     m_out_char,
    input wire logic                           m_last,
    input wire logic                           psel,
    input wire logic                           penable,
    input wire logic                           pwrite,
    input wire logic                           pready,
    input wire logic [mtc_pkg::APB_ADDR_W-1:0] paddr,
    input wire logic [mtc_pkg::APB_DATA_W-1:0] pwdata,
    input wire logic [mtc_pkg::APB_DATA_W-1:0] prdata
);
    import mtc_pkg::*;

    // no stale result survives reset
    `MTC_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_valid)

    // a stalled result transfer holds its payload
    `MTC_ASSERT(a_out_hold, aclk, aresetn,
        m_valid && !m_ready |=> m_valid && $stable(m_out_char) && $stable(m_last))

    // newline always closes the results of its character
    `MTC_ASSERT(a_newline_last, aclk, aresetn, m_valid && m_out_char == CH_NL |-> m_last)

    // a direction write reads back on the next cycle
    `MTC_ASSERT(a_cfg_readback, aclk, aresetn,
        psel && penable && pwrite && pready && paddr[APB_ADDR_W-1] == REG_DIRECTION |=>
        paddr[APB_ADDR_W-1] != REG_DIRECTION || prdata[0] == $past(pwdata[0]))

endmodule

bind morse_text_codec mtc_checker u_mtc_checker (.*);

`default_nettype wire
